[hdl/assert_macros.svh]
// assertion macros for the rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication, consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/aspe_pkg.sv]
// package for the aging slot pool: constants, result kinds, link codes
// no dependencies
package aspe_pkg;
   localparam int SLOTS = 64;
   localparam int SLOT_W = 6;
   localparam int LINK_W = 7;
   localparam logic [LINK_W-1:0] NIL = 7'h7f;
   localparam logic [7:0] FADE_MAX = 8'd255;
   localparam logic [19:0] LIFE_RESET = 20'd10000;
   localparam logic [19:0] FADE_RESET = 20'd1000;
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_SWEEP = 1'b1;
   localparam logic [2:0] KIND_ALLOC = 3'd0;
   localparam logic [2:0] KIND_FREED = 3'd1;
   localparam logic [2:0] KIND_KEPT = 3'd2;
   localparam logic [2:0] KIND_EMPTY = 3'd3;
   localparam logic [2:0] KIND_DISABLED = 3'd4;
   localparam logic [1:0] REG_ENABLED = 2'd0;
   localparam logic [1:0] REG_LIFE = 2'd1;
   localparam logic [1:0] REG_FADE = 2'd2;
   typedef struct packed {
      logic [2:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [6:0] evicted;
      logic [7:0] fade;
      logic fading;
      logic last;
   } result_type;
endpackage

[hdl/aging_slot_pool_with_eviction.sv]
// aging slot pool with lru-style eviction and a fading sweep
// depends on aspe_pkg and assert_macros.svh
// steps: alloc runs EV_RD, EV_CHK, EV_NW, EV_OD, EV_FR per evicted slot, then AL_RD, AL_WR,
// AL_HD; a sweep runs SW_RD, SW_CHK per slot, then SW_NW, SW_OD, SW_FR for a freed slot or
// SW_MUL and a 28-step bit-serial divide by fade for a fading slot; all words go via ST_OUT
// throughput: one item at a time; a stalled result word holds the walk, and the next item
// is accepted once its last word is taken
// reset: synchronous; a clearing pass over all 64 slots sets older link i to i+1, input held off
`include "assert_macros.svh"
module aging_slot_pool_with_eviction (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // now[30:0], then zero pad
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // slot[5:0], evicted[12:6], fade[20:13], pad
   output logic [3:0]  rsp_tuser,   // kind[2:0], fading[3]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   localparam int SW = aspe_pkg::SLOT_W;
   localparam int LW = aspe_pkg::LINK_W;

   localparam logic [4:0] ST_CLEAR = 5'd0;
   localparam logic [4:0] ST_IDLE = 5'd1;
   localparam logic [4:0] ST_EV_RD = 5'd2;   // read stamp/links of tail
   localparam logic [4:0] ST_EV_CHK = 5'd3;
   localparam logic [4:0] ST_EV_NW = 5'd4;   // fix older link of newer
   localparam logic [4:0] ST_AL_RD = 5'd5;   // read older link of free head
   localparam logic [4:0] ST_AL_WR = 5'd6;
   localparam logic [4:0] ST_AL_HD = 5'd7;   // fix newer link of old head
   localparam logic [4:0] ST_SW_RD = 5'd8;
   localparam logic [4:0] ST_SW_CHK = 5'd9;
   localparam logic [4:0] ST_SW_NW = 5'd10;
   localparam logic [4:0] ST_SW_OD = 5'd11;
   localparam logic [4:0] ST_SW_FR = 5'd12;
   localparam logic [4:0] ST_DIV = 5'd13;
   localparam logic [4:0] ST_OUT = 5'd14;
   localparam logic [4:0] ST_EV_OD = 5'd15;
   localparam logic [4:0] ST_EV_FR = 5'd16;
   localparam logic [4:0] ST_SW_MUL = 5'd17;

   // memories: stamp, newer link, older link
   logic [30:0] stamp_mem [aspe_pkg::SLOTS];
   logic [LW-1:0] newer_mem [aspe_pkg::SLOTS];
   logic [LW-1:0] older_mem [aspe_pkg::SLOTS];
   logic [30:0] stamp_rd;
   logic [LW-1:0] newer_rd, older_rd;

   logic [4:0] state_ff, state_in;
   logic [4:0] after_out_ff, after_out_in;
   logic enabled_ff;
   logic [19:0] life_ff, fade_ff;
   logic [LW-1:0] free_head_ff, free_head_in, used_head_ff, used_head_in;
   logic [LW-1:0] used_tail_ff, used_tail_in;
   logic [30:0] now_ff, now_in, oldest_ff, oldest_in;
   logic [LW-1:0] cur_ff, cur_in, nxt_ff, nxt_in, nw_ff, nw_in;
   logic [6:0] ev_ff, ev_in;
   logic first_ff, first_in;
   logic [27:0] rem_ff, rem_in;      // dividend remainder
   logic [27:0] quo_ff, quo_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [19:0] tval_ff, tval_in;
   aspe_pkg::result_type res_ff, res_in;
   // output word register, so the walk can build the next word while one waits
   aspe_pkg::result_type out_ff, out_in;
   logic out_v_ff, out_v_in;

   // memory port controls
   logic s_we, n_we, o_we;
   logic [SW-1:0] s_wa, n_wa, o_wa, rd_a;
   logic [30:0] s_wd;
   logic [LW-1:0] n_wd, o_wd;

   always_ff @(posedge clock) begin
      if (s_we) stamp_mem[s_wa] <= s_wd;
      if (n_we) newer_mem[n_wa] <= n_wd;
      if (o_we) older_mem[o_wa] <= o_wd;
      stamp_rd <= stamp_mem[rd_a];
      newer_rd <= newer_mem[rd_a];
      older_rd <= older_mem[rd_a];
   end

   // t = stamp + life - now, signed 34 bits
   logic signed [33:0] t_val;
   assign t_val = $signed({3'b0, stamp_rd}) + $signed({14'b0, life_ff})
                - $signed({3'b0, now_ff});
   logic [27:0] trial;
   assign trial = {rem_ff[26:0], quo_ff[27]} ;

   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {3'b0, out_ff.fade, out_ff.evicted, out_ff.slot};
   assign rsp_tuser = {out_ff.fading, out_ff.kind};
   assign rsp_tlast = out_ff.last;

   always_comb begin
      state_in = state_ff;
      after_out_in = after_out_ff;
      free_head_in = free_head_ff;
      used_head_in = used_head_ff;
      used_tail_in = used_tail_ff;
      now_in = now_ff;
      oldest_in = oldest_ff;
      cur_in = cur_ff;
      nxt_in = nxt_ff;
      nw_in = nw_ff;
      ev_in = ev_ff;
      first_in = first_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      tval_in = tval_ff;
      res_in = res_ff;
      out_in = out_ff;
      out_v_in = out_v_ff && !rsp_tready;
      s_we = 1'b0;
      n_we = 1'b0;
      o_we = 1'b0;
      s_wa = cur_ff[SW-1:0];
      n_wa = cur_ff[SW-1:0];
      o_wa = cur_ff[SW-1:0];
      s_wd = now_ff;
      n_wd = aspe_pkg::NIL;
      o_wd = aspe_pkg::NIL;
      rd_a = cur_ff[SW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            o_we = 1'b1;
            o_wd = (cur_ff == LW'(aspe_pkg::SLOTS - 1)) ? aspe_pkg::NIL : cur_ff + 1'b1;
            cur_in = cur_ff + 1'b1;
            if (cur_ff == LW'(aspe_pkg::SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               now_in = req_tdata[30:0];
               ev_in = '0;
               first_in = 1'b1;
               res_in = '0;
               res_in.last = 1'b1;
               if (req_tuser == aspe_pkg::CMD_ALLOC) begin
                  if (free_head_ff[LW-1] && !used_tail_ff[LW-1]) begin
                     cur_in = used_tail_ff;
                     state_in = ST_EV_RD;
                  end else if (free_head_ff[LW-1]) begin
                     res_in.kind = aspe_pkg::KIND_EMPTY;
                     after_out_in = ST_IDLE;
                     state_in = ST_OUT;
                  end else begin
                     cur_in = free_head_ff;
                     state_in = ST_AL_RD;
                  end
               end else if (!enabled_ff) begin
                  res_in.kind = aspe_pkg::KIND_DISABLED;
                  after_out_in = ST_IDLE;
                  state_in = ST_OUT;
               end else if (used_head_ff[LW-1]) begin
                  res_in.kind = aspe_pkg::KIND_EMPTY;
                  after_out_in = ST_IDLE;
                  state_in = ST_OUT;
               end else begin
                  cur_in = used_head_ff;
                  state_in = ST_SW_RD;
               end
            end
         end
         // eviction from the tail
         ST_EV_RD: state_in = ST_EV_CHK;
         ST_EV_CHK: begin
            if (first_ff) oldest_in = stamp_rd;
            first_in = 1'b0;
            if (!first_ff && (stamp_rd != oldest_ff || ev_ff == 7'(aspe_pkg::SLOTS))) begin
               cur_in = free_head_ff;
               state_in = ST_AL_RD;
            end else begin
               nw_in = newer_rd;
               nxt_in = older_rd;
               state_in = ST_EV_NW;
            end
         end
         ST_EV_NW: begin
            // tail has no older link, so only the newer side changes
            if (!nw_ff[LW-1]) begin
               o_we = 1'b1;
               o_wa = nw_ff[SW-1:0];
               o_wd = nxt_ff;
            end else used_head_in = nxt_ff;
            state_in = ST_EV_OD;
         end
         ST_EV_OD: begin
            if (!nxt_ff[LW-1]) begin
               n_we = 1'b1;
               n_wa = nxt_ff[SW-1:0];
               n_wd = nw_ff;
            end else used_tail_in = nw_ff;
            state_in = ST_EV_FR;
         end
         ST_EV_FR: begin
            o_we = 1'b1;
            o_wd = free_head_ff;
            n_we = 1'b1;
            free_head_in = cur_ff;
            ev_in = ev_ff + 1'b1;
            if (used_tail_in[LW-1]) begin
               cur_in = cur_ff;
               state_in = ST_AL_RD;
            end else begin
               cur_in = used_tail_in;
               state_in = ST_EV_RD;
            end
            if (used_tail_in[LW-1]) cur_in = cur_ff;
         end
         ST_AL_RD: begin
            cur_in = free_head_ff;
            rd_a = free_head_ff[SW-1:0];
            state_in = ST_AL_WR;
         end
         ST_AL_WR: begin
            free_head_in = older_rd;
            s_we = 1'b1;
            n_we = 1'b1;
            o_we = 1'b1;
            o_wd = used_head_ff;
            state_in = ST_AL_HD;
         end
         ST_AL_HD: begin
            if (!used_head_ff[LW-1]) begin
               n_we = 1'b1;
               n_wa = used_head_ff[SW-1:0];
               n_wd = cur_ff;
            end else used_tail_in = cur_ff;
            used_head_in = cur_ff;
            res_in.kind = aspe_pkg::KIND_ALLOC;
            res_in.slot = cur_ff[SW-1:0];
            res_in.evicted = ev_ff;
            res_in.last = 1'b1;
            after_out_in = ST_IDLE;
            state_in = ST_OUT;
         end
         // sweep walk
         ST_SW_RD: state_in = ST_SW_CHK;
         ST_SW_CHK: begin
            nxt_in = older_rd;
            nw_in = newer_rd;
            res_in = '0;
            res_in.slot = cur_ff[SW-1:0];
            res_in.last = older_rd[LW-1];
            if (t_val < 0) begin
               res_in.kind = aspe_pkg::KIND_FREED;
               state_in = ST_SW_NW;
            end else if (t_val < $signed({14'b0, fade_ff})) begin
               res_in.kind = aspe_pkg::KIND_KEPT;
               res_in.fading = 1'b1;
               tval_in = t_val[19:0];
               state_in = ST_SW_MUL;
            end else begin
               res_in.kind = aspe_pkg::KIND_KEPT;
               res_in.fade = aspe_pkg::FADE_MAX;
               after_out_in = ST_SW_RD;
               state_in = ST_OUT;
            end
         end
         ST_SW_MUL: begin
            // 255*t as dividend, restoring divide one bit a cycle
            quo_in = ({8'b0, tval_ff} << 8) - {8'b0, tval_ff};
            rem_in = '0;
            cnt_in = 5'd28;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial >= {8'b0, fade_ff}) begin
               rem_in = trial - {8'b0, fade_ff};
               quo_in = {quo_ff[26:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[26:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 5'd1) begin
               res_in.fade = quo_in[7:0];
               after_out_in = ST_SW_RD;
               state_in = ST_OUT;
            end
         end
         ST_SW_NW: begin
            if (!nw_ff[LW-1]) begin
               o_we = 1'b1;
               o_wa = nw_ff[SW-1:0];
               o_wd = nxt_ff;
            end else used_head_in = nxt_ff;
            state_in = ST_SW_OD;
         end
         ST_SW_OD: begin
            if (!nxt_ff[LW-1]) begin
               n_we = 1'b1;
               n_wa = nxt_ff[SW-1:0];
               n_wd = nw_ff;
            end else used_tail_in = nw_ff;
            state_in = ST_SW_FR;
         end
         ST_SW_FR: begin
            o_we = 1'b1;
            o_wd = free_head_ff;
            n_we = 1'b1;
            free_head_in = cur_ff;
            after_out_in = ST_SW_RD;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hand the word over once the output register is free
            if (!out_v_ff || rsp_tready) begin
               out_in = res_ff;
               out_v_in = 1'b1;
               if (after_out_ff == ST_IDLE || res_ff.last) state_in = ST_IDLE;
               else begin
                  cur_in = nxt_ff;
                  state_in = ST_SW_RD;
               end
            end
            rd_a = nxt_ff[SW-1:0];
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         after_out_ff <= ST_IDLE;
         cur_ff <= '0;
         free_head_ff <= '0;
         used_head_ff <= aspe_pkg::NIL;
         used_tail_ff <= aspe_pkg::NIL;
         out_v_ff <= 1'b0;
         enabled_ff <= 1'b1;
         life_ff <= aspe_pkg::LIFE_RESET;
         fade_ff <= aspe_pkg::FADE_RESET;
      end else begin
         state_ff <= state_in;
         after_out_ff <= after_out_in;
         cur_ff <= cur_in;
         free_head_ff <= free_head_in;
         used_head_ff <= used_head_in;
         used_tail_ff <= used_tail_in;
         out_v_ff <= out_v_in;
         if (csr_we) begin
            unique case (csr_index)
               aspe_pkg::REG_ENABLED: enabled_ff <= csr_wdata[0];
               aspe_pkg::REG_LIFE: life_ff <= csr_wdata;
               aspe_pkg::REG_FADE: fade_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      now_ff <= now_in;
      oldest_ff <= oldest_in;
      nxt_ff <= nxt_in;
      nw_ff <= nw_in;
      ev_ff <= ev_in;
      first_ff <= first_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      tval_ff <= tval_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   `ASSERT_ALWAYS(a_ready_idle, clock, reset, !req_tready || state_ff == ST_IDLE,
      "ready outside idle")
   `ASSERT_ALWAYS(a_ends_link, clock, reset,
      used_head_ff[LW-1] == used_tail_ff[LW-1] || state_ff != ST_IDLE,
      "head and tail disagree on empty list")
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "result dropped while stalled")
   `ASSERT_ALWAYS(a_ev_bound, clock, reset,
      ev_ff <= 7'(aspe_pkg::SLOTS) || state_ff == ST_IDLE || state_ff == ST_CLEAR,
      "eviction count out of range")
endmodule

[tb/testbench.sv]
// testbench for aging_slot_pool_with_eviction: stream driver, monitor and pool predictor
// depends on aspe_pkg and the rtl of the slot pool
`timescale 1ns / 1ps
module testbench;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // now[30:0], then zero pad
   logic        req_tuser = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // slot[5:0], evicted[12:6], fade[20:13], pad
   logic [3:0]  rsp_tuser;        // kind[2:0], fading[3]
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [19:0] csr_wdata = '0;

   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD = 1500;

   typedef struct {
      bit         cmd;
      logic [30:0] now;
   } pool_cmd_type;

   aging_slot_pool_with_eviction uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // pool predictor: its own copy of the lists, stamps and registers
   // ---------------------------------------------------------------
   logic [30:0]                 slot_stamp [aspe_pkg::SLOTS];
   logic [aspe_pkg::LINK_W-1:0] toward_newer [aspe_pkg::SLOTS];
   logic [aspe_pkg::LINK_W-1:0] toward_older [aspe_pkg::SLOTS];
   logic [aspe_pkg::LINK_W-1:0] free_top, newest, oldest;
   bit                          pool_enabled;
   logic [19:0]                 life_len, fade_len;

   pool_cmd_type         pending_cmds [$];
   aspe_pkg::result_type expected_words [$];

   function automatic bit is_slot(input logic [aspe_pkg::LINK_W-1:0] s);
      return s < aspe_pkg::SLOTS;
   endfunction

   task automatic pool_reset();
      for (int i = 0; i < aspe_pkg::SLOTS; i++) begin
         slot_stamp[i] = '0;
         toward_newer[i] = aspe_pkg::NIL;
         toward_older[i] = (i + 1 < aspe_pkg::SLOTS) ? aspe_pkg::LINK_W'(i + 1)
                                                    : aspe_pkg::NIL;
      end
      free_top = '0;
      newest = aspe_pkg::NIL;
      oldest = aspe_pkg::NIL;
      pool_enabled = 1'b1;
      life_len = aspe_pkg::LIFE_RESET;
      fade_len = aspe_pkg::FADE_RESET;
   endtask

   // unlink a used slot and push it on the free list
   task automatic free_slot(input logic [aspe_pkg::LINK_W-1:0] s);
      logic [aspe_pkg::LINK_W-1:0] nw, od;
      nw = toward_newer[s];
      od = toward_older[s];
      if (is_slot(nw)) toward_older[nw] = od; else newest = od;
      if (is_slot(od)) toward_newer[od] = nw; else oldest = nw;
      toward_older[s] = free_top;
      toward_newer[s] = aspe_pkg::NIL;
      free_top = s;
   endtask

   task automatic pool_predict(input bit cmd, input logic [30:0] now);
      aspe_pkg::result_type r;
      logic [aspe_pkg::LINK_W-1:0] s, nxt;
      logic [30:0] tail_stamp;
      int ev, n;
      longint remaining;
      r = '0;
      if (cmd == aspe_pkg::CMD_ALLOC) begin
         ev = 0;
         // pool full: evict every slot sharing the oldest stamp
         if (!is_slot(free_top) && is_slot(oldest)) begin
            tail_stamp = slot_stamp[oldest];
            while (is_slot(oldest) && slot_stamp[oldest] == tail_stamp
                   && ev < aspe_pkg::SLOTS) begin
               free_slot(oldest);
               ev++;
            end
         end
         r.evicted = 7'(ev);
         r.last = 1'b1;
         s = free_top;
         if (!is_slot(s)) begin
            r.kind = aspe_pkg::KIND_EMPTY;
            expected_words.push_back(r);
            return;
         end
         free_top = toward_older[s];
         slot_stamp[s] = now;
         toward_newer[s] = aspe_pkg::NIL;
         toward_older[s] = newest;
         if (is_slot(newest)) toward_newer[newest] = s; else oldest = s;
         newest = s;
         r.kind = aspe_pkg::KIND_ALLOC;
         r.slot = s[aspe_pkg::SLOT_W-1:0];
         expected_words.push_back(r);
         return;
      end
      if (!pool_enabled || !is_slot(newest)) begin
         r.kind = pool_enabled ? aspe_pkg::KIND_EMPTY : aspe_pkg::KIND_DISABLED;
         r.last = 1'b1;
         expected_words.push_back(r);
         return;
      end
      // sweep newest to oldest
      s = newest;
      n = 0;
      while (is_slot(s) && n < aspe_pkg::SLOTS) begin
         nxt = toward_older[s];
         remaining = longint'(slot_stamp[s]) + longint'(life_len) - longint'(now);
         r = '0;
         r.slot = s[aspe_pkg::SLOT_W-1:0];
         if (remaining < 0) begin
            free_slot(s);
            r.kind = aspe_pkg::KIND_FREED;
         end else if (remaining < longint'(fade_len)) begin
            r.kind = aspe_pkg::KIND_KEPT;
            r.fade = 8'((longint'(aspe_pkg::FADE_MAX) * remaining) / longint'(fade_len));
            r.fading = 1'b1;
         end else begin
            r.kind = aspe_pkg::KIND_KEPT;
            r.fade = aspe_pkg::FADE_MAX;
         end
         expected_words.push_back(r);
         n++;
         s = nxt;
      end
      expected_words[expected_words.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // request driver: gaps drawn per word, zero in calm phases
   // ---------------------------------------------------------------
   bit           calm = 1'b0;
   int           req_gap = 0;
   pool_cmd_type next_cmd;
   int           accepted_words = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pool_predict(req_tuser, req_tdata[30:0]);
            accepted_words++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               next_cmd = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_cmd.cmd;
               req_tdata <= {1'b0, next_cmd.now};
               req_gap = calm ? 0 : $urandom_range(0, 16);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // result monitor: per-word stall, plus one long hold-off on request
   // ---------------------------------------------------------------
   int                   rsp_stall = 0;
   int                   hold_left = 0;
   bit                   hold_armed = 1'b0;
   int                   errors = 0;
   aspe_pkg::result_type want;

   task automatic report(input string what, input int got, input int exp_val);
      $display("mismatch in %s: got %0d, expected %0d", what, got, exp_val);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (hold_armed) begin
            hold_left = LONG_HOLD;
            hold_armed = 1'b0;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report("unexpected word, kind", rsp_tuser[2:0], 0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tuser[2:0] != want.kind) report("kind", rsp_tuser[2:0], want.kind);
               if (rsp_tdata[5:0] != want.slot) report("slot", rsp_tdata[5:0], want.slot);
               if (rsp_tdata[12:6] != want.evicted)
                  report("evicted", rsp_tdata[12:6], want.evicted);
               if (rsp_tdata[20:13] != want.fade) report("fade", rsp_tdata[20:13], want.fade);
               if (rsp_tuser[3] != want.fading) report("fading", rsp_tuser[3], want.fading);
               if (rsp_tlast != want.last) report("last", rsp_tlast, want.last);
            end
            rsp_stall = calm ? 0 : $urandom_range(0, 16);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         if (hold_left > 0) hold_left--;
         rsp_tready <= (hold_left == 0 && rsp_stall == 0);
      end
   end

   // watchdog: cycles with no handshake on either side
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   task automatic queue_cmd(input bit cmd, input longint now);
      pool_cmd_type c;
      c.cmd = cmd;
      c.now = 31'(now);
      pending_cmds.push_back(c);
   endtask

   // block is idle once every queued word went in and every result came back
   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_tvalid || expected_words.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [19:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         aspe_pkg::REG_ENABLED: pool_enabled = value[0];
         aspe_pkg::REG_LIFE:    life_len = value;
         aspe_pkg::REG_FADE:    fade_len = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   localparam longint NOW_MAX = 64'h7FFF_FFFF;

   initial begin
      longint t;
      int span;
      pool_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: empty sweep, full life, fading, then expiry of both slots
      queue_cmd(aspe_pkg::CMD_SWEEP, 0);
      queue_cmd(aspe_pkg::CMD_ALLOC, 0);
      queue_cmd(aspe_pkg::CMD_ALLOC, 0);
      queue_cmd(aspe_pkg::CMD_SWEEP, 0);
      queue_cmd(aspe_pkg::CMD_SWEEP, 9500);
      queue_cmd(aspe_pkg::CMD_SWEEP, 10000);
      queue_cmd(aspe_pkg::CMD_SWEEP, 10001);
      queue_cmd(aspe_pkg::CMD_SWEEP, 10001);
      wait_drained();

      // disabled: sweeps report disabled, allocation still works
      write_reg(aspe_pkg::REG_ENABLED, 20'd0);
      queue_cmd(aspe_pkg::CMD_SWEEP, 20000);
      queue_cmd(aspe_pkg::CMD_ALLOC, 20000);
      queue_cmd(aspe_pkg::CMD_SWEEP, 20001);
      wait_drained();

      // longest life and fade; fill the pool with one stamp so all 64 go at once
      write_reg(aspe_pkg::REG_ENABLED, 20'd1);
      write_reg(aspe_pkg::REG_LIFE, 20'hFFFFF);
      write_reg(aspe_pkg::REG_FADE, 20'hFFFFF);
      calm = 1'b1;
      for (int i = 0; i < aspe_pkg::SLOTS; i++) queue_cmd(aspe_pkg::CMD_ALLOC, 30000);
      queue_cmd(aspe_pkg::CMD_ALLOC, NOW_MAX);
      // time running backwards: stamp ahead of now
      queue_cmd(aspe_pkg::CMD_SWEEP, 0);
      queue_cmd(aspe_pkg::CMD_SWEEP, NOW_MAX);
      wait_drained();
      calm = 1'b0;

      // zero life and zero fade
      write_reg(aspe_pkg::REG_LIFE, 20'd0);
      write_reg(aspe_pkg::REG_FADE, 20'd0);
      queue_cmd(aspe_pkg::CMD_SWEEP, NOW_MAX);
      queue_cmd(aspe_pkg::CMD_ALLOC, 1000);
      queue_cmd(aspe_pkg::CMD_SWEEP, 1000);
      queue_cmd(aspe_pkg::CMD_SWEEP, 1001);
      wait_drained();

      // shortest nonzero settings
      write_reg(aspe_pkg::REG_LIFE, 20'd1);
      write_reg(aspe_pkg::REG_FADE, 20'd1);
      queue_cmd(aspe_pkg::CMD_ALLOC, 5000);
      queue_cmd(aspe_pkg::CMD_SWEEP, 5001);
      queue_cmd(aspe_pkg::CMD_SWEEP, 5002);
      wait_drained();

      // random phases: mostly allocations with slowly advancing time
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(aspe_pkg::REG_LIFE, 20'($urandom_range(1, 3000)));
         write_reg(aspe_pkg::REG_FADE, 20'($urandom_range(1, 3000)));
         calm = (ph == 2);
         if (ph == 1) hold_armed = 1'b1;  // receiver goes quiet, sender keeps offering
         t = $urandom_range(0, 32'h7FF0_0000);
         span = life_len / 6 + 1;
         for (int k = 0; k < 26; k++) begin
            if ($urandom_range(0, 4) != 0) t += $urandom_range(0, span);
            if (t > NOW_MAX) t = NOW_MAX;
            queue_cmd($urandom_range(0, 9) < 3 ? aspe_pkg::CMD_SWEEP : aspe_pkg::CMD_ALLOC, t);
         end
         queue_cmd(aspe_pkg::CMD_SWEEP, t);
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
